[rtl/dltq_pkg.sv]
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and codes for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAX_RESULTS = 16;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	localparam logic [2:0] KIND_DONE      = 3'd0;
	localparam logic [2:0] KIND_EXPIRED   = 3'd1;
	localparam logic [2:0] KIND_FULL      = 3'd2;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
	localparam logic [2:0] KIND_IDLE      = 3'd4;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] delta;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SHIFT,
		ST_INS_WR,
		ST_RESP,
		ST_TK_RD,
		ST_TK_CHK,
		ST_TK_LAST
	} state_t;

endpackage

[rtl/delta_list_timer_queue.sv]
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Retransmission timer queue held as a delta list in one entry memory.
//
//   channel | valid     | ready     | payload
//   cmd     | cmd_valid | cmd_ready | func, seq, delay_ms
//   res     | res_valid | res_ready | kind, out_seq, last
//
// One item at a time; the entry memory has one read and one write port and
// its read data is registered. Insert: a search walk, then shifting the
// tail up one entry per cycle. Delete: a search walk, then shifting the
// tail down. Tick: reads the head entry, then pops expired entries. The list
// is a ring (head pointer), so expiry pops cost no shift. Reset clears head
// and count; no clear pass. A stalled result register holds the sequencer
// only when it must emit.
// ----------------------------------------------------------------------------
module delta_list_timer_queue
	import dltq_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  func,
	input  logic [31:0] seq,
	input  logic [31:0] delay_ms,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  kind,
	output logic [31:0] out_seq,
	output logic        last
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int NW    = $clog2(MAX_RESULTS + 1);

	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
			input logic [CNT_W-1:0] l);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(hd) + (CNT_W+1)'(l);
		if (sum >= (CNT_W+1)'(ENTRIES))
			sum = sum - (CNT_W+1)'(ENTRIES);
		return IDX_W'(sum);
	endfunction

	entry_t mem [ENTRIES];
	entry_t rd_data_q;

	state_t state_q, state_d;

	logic [1:0]       op_q;
	logic [31:0]      s_q;
	logic [31:0]      rem_q;
	logic [2:0]       rk_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] head_q;
	logic [NW-1:0]    n_q;
	logic             pend_q;
	logic [31:0]      pend_seq_q;
	logic             v_s1;
	logic [CNT_W-1:0] idx_s1;

	logic             res_valid_q;
	logic [2:0]       kind_q;
	logic [31:0]      out_seq_q;
	logic             last_q;

	logic             is_ins, full, walk_last, ins_hit, del_hit, hit, walk_end;
	logic             emit_ok, tk_exp, tk_more, pop;
	logic [31:0]      tk_eff;
	logic [CNT_W-1:0] cnt_dec;
	logic [NW-1:0]    n_inc;

	logic             rd_en, wr_en, emit, emit_last;
	logic [CNT_W-1:0] rd_lidx, wr_lidx;
	entry_t           wr_data;
	logic [2:0]       emit_kind;
	logic [31:0]      emit_seq;

	assign is_ins    = (op_q == FUNC_INSERT);
	assign full      = (count_q == CNT_W'(ENTRIES));
	assign walk_last = (rd_idx_q == count_q);
	assign ins_hit   = v_s1 && (rem_q < rd_data_q.delta);
	assign del_hit   = v_s1 && (rd_data_q.seq == s_q);
	assign hit       = is_ins ? ins_hit : del_hit;
	assign walk_end  = !v_s1 && walk_last;
	assign emit_ok   = !res_valid_q || res_ready;
	assign tk_eff    = pend_q ? rd_data_q.delta
	                          : rd_data_q.delta - 32'(rd_data_q.delta != 32'd0);
	assign tk_exp    = (tk_eff == 32'd0);
	assign cnt_dec   = count_q - CNT_W'(1);
	assign n_inc     = n_q + NW'(1);
	assign tk_more   = (cnt_dec != '0) && (n_inc < NW'(MAX_RESULTS));
	assign pop       = (state_q == ST_TK_CHK) && tk_exp && (!pend_q || emit_ok);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (func == FUNC_INSERT)
						state_d = full ? ST_RESP : ST_WALK;
					else if (func == FUNC_DELETE)
						state_d = ST_WALK;
					else if (func == FUNC_TICK)
						state_d = ST_TK_RD;
					else
						state_d = ST_RESP;
				end
			end
			ST_WALK: begin
				if (hit)
					state_d = ST_SHIFT;
				else if (walk_end)
					state_d = is_ins ? ST_INS_WR : ST_RESP;
			end
			ST_SHIFT: begin
				if (left_q == '0 && !v_s1)
					state_d = is_ins ? ST_INS_WR : ST_RESP;
			end
			ST_INS_WR: state_d = ST_RESP;
			ST_RESP: begin
				if (emit_ok)
					state_d = ST_IDLE;
			end
			ST_TK_RD: begin
				if (count_q != '0)
					state_d = ST_TK_CHK;
				else if (emit_ok)
					state_d = ST_IDLE;
			end
			ST_TK_CHK: begin
				if (pop)
					state_d = tk_more ? ST_TK_CHK : ST_TK_LAST;
				else if (!tk_exp && emit_ok)
					state_d = ST_IDLE;
			end
			ST_TK_LAST: begin
				if (emit_ok)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and result controls
	always_comb begin
		rd_en     = 1'b0;
		rd_lidx   = rd_idx_q;
		wr_en     = 1'b0;
		wr_lidx   = pos_q;
		wr_data   = '{seq: s_q, delta: rem_q};
		emit      = 1'b0;
		emit_kind = KIND_DONE;
		emit_seq  = 32'd0;
		emit_last = 1'b1;
		unique case (state_q)
			ST_IDLE: ;
			ST_WALK: rd_en = !hit && !walk_last;
			ST_SHIFT: begin
				rd_en = (left_q != '0);
				wr_en = v_s1;
				wr_data.seq = rd_data_q.seq;
				if (is_ins) begin
					wr_lidx = idx_s1 + CNT_W'(1);
					wr_data.delta = (idx_s1 == pos_q) ? rd_data_q.delta - rem_q
					                                  : rd_data_q.delta;
				end else begin
					wr_lidx = idx_s1 - CNT_W'(1);
					wr_data.delta = (idx_s1 == pos_q + CNT_W'(1))
						? rd_data_q.delta + rem_q : rd_data_q.delta;
				end
			end
			ST_INS_WR: wr_en = 1'b1;
			ST_RESP: begin
				emit      = emit_ok;
				emit_kind = rk_q;
				emit_seq  = (op_q == FUNC_INSERT || op_q == FUNC_DELETE) ? s_q : 32'd0;
			end
			ST_TK_RD: begin
				if (count_q != '0) begin
					rd_en   = 1'b1;
					rd_lidx = '0;
				end else begin
					emit      = emit_ok;
					emit_kind = KIND_IDLE;
				end
			end
			ST_TK_CHK: begin
				rd_lidx = CNT_W'(1);
				rd_en   = pop && tk_more;
				if (!pend_q && !tk_exp) begin
					emit      = emit_ok;
					emit_kind = KIND_IDLE;
					wr_en     = emit_ok;
					wr_lidx   = '0;
					wr_data   = '{seq: rd_data_q.seq, delta: tk_eff};
				end else if (pend_q) begin
					emit      = emit_ok;
					emit_kind = KIND_EXPIRED;
					emit_seq  = pend_seq_q;
					emit_last = !tk_exp;
				end
			end
			ST_TK_LAST: begin
				emit      = emit_ok;
				emit_kind = KIND_EXPIRED;
				emit_seq  = pend_seq_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[phys(head_q, wr_lidx)] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[phys(head_q, rd_lidx)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			v_s1        <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					v_s1   <= 1'b0;
					pend_q <= 1'b0;
				end
				ST_WALK: v_s1 <= rd_en;
				ST_SHIFT: begin
					v_s1 <= rd_en;
					if (state_d != ST_SHIFT && !is_ins)
						count_q <= cnt_dec;
				end
				ST_INS_WR: count_q <= count_q + CNT_W'(1);
				ST_TK_CHK: begin
					if (pop) begin
						pend_q  <= 1'b1;
						count_q <= cnt_dec;
						head_q  <= (head_q == IDX_W'(ENTRIES - 1)) ? '0
						                                          : head_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q    <= emit_kind;
			out_seq_q <= emit_seq;
			last_q    <= emit_last;
		end
		unique case (state_q)
			ST_IDLE: begin
				op_q     <= func;
				s_q      <= seq;
				rem_q    <= delay_ms;
				rd_idx_q <= '0;
				n_q      <= '0;
				rk_q     <= (func == FUNC_INSERT && full) ? KIND_FULL : KIND_DONE;
			end
			ST_WALK: begin
				idx_s1 <= rd_idx_q;
				if (rd_en)
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (hit) begin
					pos_q <= idx_s1;
					if (is_ins) begin
						left_q   <= count_q - idx_s1;
						rd_idx_q <= cnt_dec;
					end else begin
						rem_q    <= rd_data_q.delta;
						left_q   <= cnt_dec - idx_s1;
						rd_idx_q <= idx_s1 + CNT_W'(1);
					end
				end else begin
					if (v_s1 && is_ins)
						rem_q <= rem_q - rd_data_q.delta;
					if (walk_end) begin
						pos_q <= count_q;
						if (!is_ins)
							rk_q <= KIND_NOT_FOUND;
					end
				end
			end
			ST_SHIFT: begin
				idx_s1 <= rd_idx_q;
				if (rd_en) begin
					left_q   <= left_q - CNT_W'(1);
					rd_idx_q <= is_ins ? rd_idx_q - CNT_W'(1) : rd_idx_q + CNT_W'(1);
				end
			end
			ST_TK_CHK: begin
				if (pop) begin
					pend_seq_q <= rd_data_q.seq;
					n_q        <= n_inc;
				end
			end
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign out_seq   = out_seq_q;
	assign last      = last_q;

endmodule

[rtl/dltq_checker.sv]
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level checks for the delta-list timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dltq_checker
	import dltq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  func,
	input logic [31:0] seq,
	input logic [31:0] delay_ms,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  kind,
	input logic [31:0] out_seq,
	input logic        last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(out_seq)
			&& $stable(last))
		else $error("result changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_DONE || kind == KIND_FULL
			|| kind == KIND_NOT_FOUND || kind == KIND_IDLE) |-> last)
		else $error("single-result kind without last");

	a_idle_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_IDLE |-> out_seq == 32'd0)
		else $error("idle tick carries a sequence number");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second item accepted back to back");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
